// ===== sv/twa_pkg.sv =====
package twa_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SAT,
    ST_SGN,
    ST_ADD,
    ST_ABS,
    ST_DIV,
    ST_FIX
  } twa_state_t;

  localparam logic [2:0] CMD_ACC       = 3'd0;
  localparam logic [2:0] CMD_YIELD     = 3'd1;
  localparam logic [2:0] CMD_RST_LAST  = 3'd2;
  localparam logic [2:0] CMD_RST_TIME  = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  localparam int TOTAL_BITS = 64;
  localparam int DIV_STEPS  = 64;

endpackage

// ===== sv/time_weighted_averager.sv =====
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// in       | in_valid in_stall in_cmd in_timestamp   | request in
//          | in_sample                               |
// out      | out_valid out_stall out_average         | result out
//          | out_elapsed_zero                        |
//
// accumulate on a started window runs one shift-add step per sample bit on the shared adder,
// then product saturation, optional negation and saturating add. yield runs absolute value,
// 64 restoring division steps, sign fix and output load; with zero elapsed ticks it goes
// straight to output load. anything else, first accumulate included, is done in idle.
// in_stall is high while a request is in progress; a yield that finishes while the output
// register is still held by out_stall waits for it. reset is synchronous, active low.
module time_weighted_averager #(
  parameter int TIME_BITS   = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_cmd,
  input  logic [TIME_BITS-1:0]          in_timestamp,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [63:0]            out_average,
  output logic                          out_elapsed_zero
);
  import twa_pkg::*;

  localparam int PW = SAMPLE_BITS + TIME_BITS;
  localparam int MW = (PW > TOTAL_BITS) ? PW : TOTAL_BITS;
  localparam int AW = MW + 1;

  twa_state_t state_r, state_nxt;

  logic [TIME_BITS-1:0]   start_r, start_nxt;
  logic [TIME_BITS-1:0]   last_r, last_nxt;
  logic [TOTAL_BITS-1:0]  total_r, total_nxt;
  logic                   started_r, started_nxt;

  logic [MW-1:0]          mcand_r, mcand_nxt;
  logic [SAMPLE_BITS-1:0] mplier_r, mplier_nxt;
  logic [MW-1:0]          prod_r, prod_nxt;
  logic [TOTAL_BITS-1:0]  dvd_r, dvd_nxt;
  logic [TIME_BITS-1:0]   rem_r, rem_nxt;
  logic [TIME_BITS-1:0]   elap_r, elap_nxt;
  logic                   neg_r, neg_nxt;
  logic                   ez_r, ez_nxt;
  logic [6:0]             cnt_r, cnt_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [TOTAL_BITS-1:0]  avg_r, avg_nxt;
  logic                   oez_r, oez_nxt;

  // shared adder / subtractor
  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_sub;

  logic                   in_acc;
  logic [TIME_BITS-1:0]   delta, elapsed;
  logic [SAMPLE_BITS-1:0] s_raw, s_mag;
  logic                   s_neg;
  logic [AW-1:0]          limit;
  logic                   ovf;
  logic                   out_free;

  assign in_acc   = in_valid && !in_stall;
  assign delta    = in_timestamp - last_r;
  assign elapsed  = last_r - start_r;
  assign s_raw    = in_sample;
  assign s_neg    = s_raw[SAMPLE_BITS-1];
  assign s_mag    = s_neg ? (~s_raw + SAMPLE_BITS'(1)) : s_raw;
  assign out_free = !out_valid_r || !out_stall;
  assign limit    = neg_r ? (AW'(1) << (TOTAL_BITS - 1))
                          : ((AW'(1) << (TOTAL_BITS - 1)) - AW'(1));

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      ST_MUL: begin
        alu_a = AW'(prod_r);
        alu_b = mplier_r[0] ? AW'(mcand_r) : '0;
      end
      ST_SAT: begin
        alu_a   = limit;
        alu_b   = AW'(prod_r);
        alu_sub = 1'b1;
      end
      ST_SGN: begin
        alu_b   = AW'(prod_r);
        alu_sub = 1'b1;
      end
      ST_ADD: begin
        alu_a = AW'(total_r);
        alu_b = AW'(prod_r[TOTAL_BITS-1:0]);
      end
      ST_ABS: begin
        alu_b   = AW'(total_r);
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = AW'({rem_r, dvd_r[TOTAL_BITS-1]});
        alu_b   = AW'(elap_r);
        alu_sub = 1'b1;
      end
      ST_FIX: begin
        alu_b   = AW'(dvd_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
    alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
  end

  // signed overflow of the total add
  assign ovf = (total_r[TOTAL_BITS-1] == prod_r[TOTAL_BITS-1]) &&
               (alu_sum[TOTAL_BITS-1] != prod_r[TOTAL_BITS-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= '0;
      last_r      <= '0;
      total_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      last_r      <= last_nxt;
      total_r     <= total_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    elap_r   <= elap_nxt;
    neg_r    <= neg_nxt;
    ez_r     <= ez_nxt;
    cnt_r    <= cnt_nxt;
    avg_r    <= avg_nxt;
    oez_r    <= oez_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    started_nxt   = started_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    prod_nxt      = prod_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    elap_nxt      = elap_r;
    neg_nxt       = neg_r;
    ez_nxt        = ez_r;
    cnt_nxt       = cnt_r;
    avg_nxt       = avg_r;
    oez_nxt       = oez_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_ACC: begin
              last_nxt    = in_timestamp;
              started_nxt = 1'b1;
              if (started_r) begin
                mcand_nxt  = MW'(delta);
                mplier_nxt = s_mag;
                neg_nxt    = s_neg;
                prod_nxt   = '0;
                cnt_nxt    = '0;
                state_nxt  = ST_MUL;
              end else begin
                start_nxt = in_timestamp;
              end
            end
            CMD_YIELD: begin
              if (elapsed == '0) begin
                ez_nxt    = 1'b1;
                state_nxt = ST_FIX;
              end else begin
                ez_nxt    = 1'b0;
                elap_nxt  = elapsed;
                neg_nxt   = total_r[TOTAL_BITS-1];
                state_nxt = ST_ABS;
              end
            end
            CMD_RST_LAST: begin
              total_nxt   = '0;
              start_nxt   = last_r;
              started_nxt = 1'b1;
            end
            CMD_RST_TIME: begin
              total_nxt   = '0;
              start_nxt   = in_timestamp;
              last_nxt    = in_timestamp;
              started_nxt = 1'b1;
            end
            CMD_CLEAR: begin
              total_nxt   = '0;
              start_nxt   = '0;
              last_nxt    = '0;
              started_nxt = 1'b0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt   = alu_sum[MW-1:0];
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 7'd1;
        if (cnt_r == 7'(SAMPLE_BITS - 1)) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        // limit - product went negative: clamp the magnitude
        if (alu_sum[AW-1]) begin
          prod_nxt = limit[MW-1:0];
        end
        state_nxt = neg_r ? ST_SGN : ST_ADD;
      end
      ST_SGN: begin
        prod_nxt  = alu_sum[MW-1:0];
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (ovf) begin
          total_nxt = neg_r ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                            : {1'b0, {(TOTAL_BITS-1){1'b1}}};
        end else begin
          total_nxt = alu_sum[TOTAL_BITS-1:0];
        end
        state_nxt = ST_IDLE;
      end
      ST_ABS: begin
        dvd_nxt   = neg_r ? alu_sum[TOTAL_BITS-1:0] : total_r;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // restoring step: keep the trial difference when it is not negative
        if (alu_sum[AW-1]) begin
          rem_nxt = {rem_r[TIME_BITS-2:0], dvd_r[TOTAL_BITS-1]};
          dvd_nxt = {dvd_r[TOTAL_BITS-2:0], 1'b0};
        end else begin
          rem_nxt = alu_sum[TIME_BITS-1:0];
          dvd_nxt = {dvd_r[TOTAL_BITS-2:0], 1'b1};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (out_free) begin
          if (ez_r) begin
            avg_nxt = total_r;
          end else if (neg_r) begin
            avg_nxt = alu_sum[TOTAL_BITS-1:0];
          end else begin
            avg_nxt = dvd_r;
          end
          oez_nxt       = ez_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_average      = avg_r;
  assign out_elapsed_zero = oez_r;

  // remainder stays below the divisor through the division
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < elap_r))
    else $error("division remainder not below divisor");

  // a result only appears after the output load step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIX))
    else $error("result raised outside output load");

  // before the first sample the window is empty
  a_not_started: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (total_r == '0 && start_r == last_r))
    else $error("state not clear before first sample");

  // multiplier never runs past the sample width
  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (cnt_r < 7'(SAMPLE_BITS)))
    else $error("multiply step count overrun");

  // a yield with ticks elapsed enters the divide path
  a_yield_path: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_YIELD && elapsed != '0) |=> (state_r == ST_ABS))
    else $error("yield did not start division");

endmodule
